// ===== design/kda_pkg.sv =====
// Shared types, constants and the log2 fraction table generator for the
// divergence aggregator. No dependencies.
`default_nettype none
package kda_pkg;

	localparam int FRAC_BITS_DEF      = 16;
	localparam int LOG_TABLE_BITS_DEF = 8;
	localparam int QUEUE_DEPTH_DEF    = 2;

	localparam int CNT_W     = 32;
	localparam int SUM_W     = 48;
	localparam int FX_W      = 64;
	localparam int PSIZE_W   = 21;
	localparam int GSIZE_W   = 24;
	localparam int GAIN_W    = 32;
	localparam int GAIN_FRAC = 16;
	localparam int IN_DATA_W  = 216;
	localparam int OUT_DATA_W = 376;
	localparam int CFG_IDX_W  = 1;

	localparam logic [CFG_IDX_W-1:0] REG_SCORE_GAIN    = 1'd0;
	localparam logic [CFG_IDX_W-1:0] REG_NEGATIVE_MODE = 1'd1;
	localparam logic [GAIN_W-1:0]    GAIN_RESET        = 32'd65536;

	localparam logic [FX_W-1:0] S64_MIN = {1'b1, {(FX_W-1){1'b0}}};
	localparam logic [FX_W-1:0] S64_MAX = {1'b0, {(FX_W-1){1'b1}}};

	// one queued item, already classified by the front end
	typedef struct packed {
		logic                leaf;
		logic [CNT_W-1:0]    value;
		logic [CNT_W-1:0]    item_ref;
		logic [FX_W-1:0]     micro;
		logic [PSIZE_W-1:0]  size;
		logic [FX_W-1:0]     div;
		logic                last;
	} item_t;

	typedef enum logic [1:0] {
		PH_LEAF  = 2'd0,
		PH_GROUP = 2'd1,
		PH_GAIN  = 2'd2
	} phase_t;

	typedef enum logic [1:0] {
		SP_NONE = 2'd0,
		SP_ZERO = 2'd1,
		SP_MIN  = 2'd2
	} spec_t;

	// fraction of log2(1 + idx/2^tbits) by repeated squaring in Q1.30
	function automatic longint unsigned log_frac(input int idx, input int fbits,
			input int tbits);
		longint unsigned y;
		longint unsigned r;
		y = ((longint'(1) << tbits) | longint'(idx)) << (30 - tbits);
		r = 0;
		for (int k = 0; k < fbits; k++) begin
			y = (y * y) >> 30;
			r = r << 1;
			if (y >= (longint'(1) << 31)) begin
				r = r | 1;
				y = y >> 1;
			end
		end
		return r;
	endfunction

endpackage
`default_nettype wire

// ===== design/kda_front.sv =====
// Input stage: takes stream words, unpacks and classifies them into queue items.
// Depends on kda_pkg.
`default_nettype none
module kda_front (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	input  wire logic                           s_tvalid,
	output logic                                s_tready,
	// item_value, item_ref, part_micro, part_size, part_divergence, zero pad
	input  wire logic [kda_pkg::IN_DATA_W-1:0]  s_tdata,
	// mode
	input  wire logic                           s_tuser,
	input  wire logic                           s_tlast,
	output logic                                push_valid,
	input  wire logic                           push_ready,
	output kda_pkg::item_t                      push_item
);

	logic           vld_s1;
	kda_pkg::item_t item_s1;
	kda_pkg::item_t item_in;

	always_comb begin
		item_in.leaf     = !s_tuser;
		item_in.value    = s_tdata[31:0];
		item_in.item_ref = s_tdata[63:32];
		item_in.last     = s_tlast;
		if (s_tuser) begin
			item_in.micro = s_tdata[127:64];
			item_in.size  = s_tdata[148:128];
			item_in.div   = s_tdata[212:149];
		end else begin
			// leaf: one leaf, no divergence, micro term computed later
			item_in.micro = '0;
			item_in.size  = kda_pkg::PSIZE_W'(1);
			item_in.div   = '0;
		end
	end

	assign s_tready   = !vld_s1 || push_ready;
	assign push_valid = vld_s1;
	assign push_item  = item_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (s_tvalid && s_tready) begin
			vld_s1 <= 1'b1;
		end else if (push_ready) begin
			vld_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			item_s1 <= item_in;
		end
	end

endmodule
`default_nettype wire

// ===== design/kda_fifo.sv =====
// Short register queue between the front end and the compute back end.
// Depends on kda_pkg.
`default_nettype none
module kda_fifo #(
	parameter int DEPTH = kda_pkg::QUEUE_DEPTH_DEF
) (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            in_valid,
	output logic                 in_ready,
	input  wire kda_pkg::item_t  in_item,
	output logic                 out_valid,
	input  wire logic            out_ready,
	output kda_pkg::item_t       out_item
);

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);

	kda_pkg::item_t   mem [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;
	logic             push;
	logic             pop;

	assign in_ready  = count_q != CNT_W'(DEPTH);
	assign out_valid = count_q != '0;
	assign out_item  = mem[rd_ptr_q];
	assign push      = in_valid && in_ready;
	assign pop       = out_valid && out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + PTR_W'(1);
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + PTR_W'(1);
			end
			if (push && !pop) begin
				count_q <= count_q + CNT_W'(1);
			end else if (pop && !push) begin
				count_q <= count_q - CNT_W'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			mem[wr_ptr_q] <= in_item;
		end
	end

endmodule
`default_nettype wire

// ===== design/kda_log.sv =====
// Fixed-point log2: leading-one detector plus a constant fraction table.
// Depends on kda_pkg (table generator).
`default_nettype none
module kda_log #(
	parameter int FRAC_BITS      = kda_pkg::FRAC_BITS_DEF,
	parameter int LOG_TABLE_BITS = kda_pkg::LOG_TABLE_BITS_DEF,
	parameter int XW             = kda_pkg::SUM_W
) (
	input  wire logic [XW-1:0]                     x,
	output logic      [$clog2(XW)+FRAC_BITS-1:0]   logv
);

	localparam int PW = $clog2(XW);
	localparam int TN = 1 << LOG_TABLE_BITS;

	logic [FRAC_BITS-1:0]         tbl [TN];
	logic [PW-1:0]                p;
	logic [XW+LOG_TABLE_BITS-1:0] ext;
	logic [LOG_TABLE_BITS-1:0]    idx;

	for (genvar g = 0; g < TN; g++) begin : g_tbl
		assign tbl[g] = FRAC_BITS'(kda_pkg::log_frac(g, FRAC_BITS, LOG_TABLE_BITS));
	end

	always_comb begin
		p = '0;
		for (int i = 0; i < XW; i++) begin
			if (x[i]) begin
				p = PW'(i);
			end
		end
	end

	// bits below the leading one, zero filled when too few exist
	assign ext  = {x, {LOG_TABLE_BITS{1'b0}}} >> p;
	assign idx  = ext[LOG_TABLE_BITS-1:0];
	assign logv = {p, tbl[idx]};

endmodule
`default_nettype wire

// ===== design/kda_back.sv =====
// Compute back end: log terms, shared 32x32 multiplier sequencer, saturating
// accumulators, group-end merge and score, output register. Depends on kda_pkg, kda_log.
`default_nettype none
module kda_back #(
	parameter int FRAC_BITS      = kda_pkg::FRAC_BITS_DEF,
	parameter int LOG_TABLE_BITS = kda_pkg::LOG_TABLE_BITS_DEF
) (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	input  wire logic                            pop_valid,
	output logic                                 pop_ready,
	input  wire kda_pkg::item_t                  pop_item,
	input  wire logic [kda_pkg::GAIN_W-1:0]      score_gain,
	input  wire logic                            score_negative_mode,
	output logic                                 m_tvalid,
	input  wire logic                            m_tready,
	output logic      [kda_pkg::OUT_DATA_W-1:0]  m_tdata,
	output logic                                 m_tuser
);

	localparam int XW = kda_pkg::SUM_W;
	localparam int FW = kda_pkg::FX_W;
	localparam int LW = $clog2(XW) + FRAC_BITS;

	typedef enum logic [7:0] {
		ST_IDLE  = 8'b0000_0001,
		ST_LOG   = 8'b0000_0010,
		ST_MLO   = 8'b0000_0100,
		ST_MHI   = 8'b0000_1000,
		ST_FIN   = 8'b0001_0000,
		ST_ACC   = 8'b0010_0000,
		ST_MERGE = 8'b0100_0000,
		ST_SCORE = 8'b1000_0000
	} state_t;

	function automatic logic [FW:0] sadd(input logic [FW-1:0] a, input logic [FW-1:0] b);
		logic [FW:0] s;
		s = {a[FW-1], a} + {b[FW-1], b};
		if (s[FW] != s[FW-1]) begin
			return {1'b1, s[FW] ? kda_pkg::S64_MIN : kda_pkg::S64_MAX};
		end
		return {1'b0, s[FW-1:0]};
	endfunction

	function automatic logic [FW:0] ssub(input logic [FW-1:0] a, input logic [FW-1:0] b);
		logic [FW:0] s;
		s = {a[FW-1], a} - {b[FW-1], b};
		if (s[FW] != s[FW-1]) begin
			return {1'b1, s[FW] ? kda_pkg::S64_MIN : kda_pkg::S64_MAX};
		end
		return {1'b0, s[FW-1:0]};
	endfunction

	state_t                         state_q;
	kda_pkg::phase_t                phase_q;
	kda_pkg::spec_t                 spec_q;
	kda_pkg::item_t                 item_q;
	logic [XW-1:0]                  acc_value_q;
	logic [XW-1:0]                  acc_ref_q;
	logic [FW-1:0]                  acc_micro_q;
	logic [FW-1:0]                  acc_div_q;
	logic [kda_pkg::GSIZE_W-1:0]    acc_size_q;
	logic                           acc_ovf_q;
	logic [FW-1:0]                  term_q;
	logic [FW-1:0]                  merged_q;
	logic [FW-1:0]                  opa_q;
	logic [31:0]                    opb_q;
	logic [FW-1:0]                  prod_lo_q;
	logic [FW-1:0]                  prod_hi_q;
	logic                           neg_q;
	logic                           out_vld_q;
	logic [kda_pkg::OUT_DATA_W-1:0] out_data_q;
	logic                           out_ovf_q;

	logic [XW-1:0]  log_x;
	logic [XW-1:0]  log_r;
	logic [LW-1:0]  lx;
	logic [LW-1:0]  lr;
	logic [LW:0]    d;
	logic [LW-1:0]  md;

	logic [95:0]    tot;
	logic [95:0]    mag;
	logic [FW-1:0]  fin_val;
	logic           fin_ovf;

	logic [XW:0]    sum_v;
	logic [XW:0]    sum_r;
	logic [kda_pkg::GSIZE_W:0] sum_sz;
	logic [FW:0]    add_micro;
	logic [FW:0]    add_div;

	logic [FW-1:0]  neg_micro;
	logic           neg_micro_ovf;
	logic [FW:0]    merge_sum;

	logic [FW-1:0]  base;
	logic [FW:0]    score_r;
	logic           out_load;

	assign log_x = (phase_q == kda_pkg::PH_LEAF) ? XW'(item_q.value) : acc_value_q;
	assign log_r = (phase_q == kda_pkg::PH_LEAF) ? XW'(item_q.item_ref) : acc_ref_q;

	kda_log #(.FRAC_BITS(FRAC_BITS), .LOG_TABLE_BITS(LOG_TABLE_BITS), .XW(XW)) u_log_x (
		.x    (log_x),
		.logv (lx)
	);

	kda_log #(.FRAC_BITS(FRAC_BITS), .LOG_TABLE_BITS(LOG_TABLE_BITS), .XW(XW)) u_log_r (
		.x    (log_r),
		.logv (lr)
	);

	assign d  = {1'b0, lx} - {1'b0, lr};
	assign md = d[LW] ? LW'(-d) : d[LW-1:0];

	// finishing a product: magnitude, then sign and clamp
	always_comb begin
		tot = {prod_hi_q, 32'b0} + {32'b0, prod_lo_q};
		if (phase_q == kda_pkg::PH_GAIN) begin
			if (prod_hi_q[FW-1:47] != '0) begin
				mag = (96'd1 << 63) + 96'd1;
			end else begin
				mag = (96'(prod_hi_q) << kda_pkg::GAIN_FRAC)
					+ 96'(prod_lo_q >> kda_pkg::GAIN_FRAC);
			end
		end else begin
			mag = tot;
		end
		fin_ovf = 1'b0;
		if (spec_q == kda_pkg::SP_ZERO) begin
			fin_val = '0;
		end else if (spec_q == kda_pkg::SP_MIN) begin
			fin_val = kda_pkg::S64_MIN;
			fin_ovf = 1'b1;
		end else if (neg_q) begin
			if (mag > (96'd1 << 63)) begin
				fin_val = kda_pkg::S64_MIN;
				fin_ovf = 1'b1;
			end else begin
				fin_val = FW'(0) - mag[FW-1:0];
			end
		end else if (mag > 96'(kda_pkg::S64_MAX)) begin
			fin_val = kda_pkg::S64_MAX;
			fin_ovf = 1'b1;
		end else begin
			fin_val = mag[FW-1:0];
		end
	end

	assign sum_v     = {1'b0, acc_value_q} + (XW + 1)'(item_q.value);
	assign sum_r     = {1'b0, acc_ref_q} + (XW + 1)'(item_q.item_ref);
	assign sum_sz    = {1'b0, acc_size_q} + (kda_pkg::GSIZE_W + 1)'(item_q.size);
	assign add_micro = sadd(acc_micro_q, term_q);
	assign add_div   = sadd(acc_div_q, item_q.div);

	assign neg_micro_ovf = acc_micro_q == kda_pkg::S64_MIN;
	assign neg_micro     = neg_micro_ovf ? kda_pkg::S64_MAX : FW'(0) - acc_micro_q;
	assign merge_sum     = sadd(neg_micro, term_q);

	assign base    = (FW'(acc_size_q) - FW'(1)) << FRAC_BITS;
	assign score_r = score_negative_mode ? ssub(FW'(0), merged_q) : ssub(base, term_q);

	assign pop_ready = state_q == ST_IDLE;
	assign out_load  = (state_q == ST_SCORE) && (!out_vld_q || m_tready);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			phase_q     <= kda_pkg::PH_LEAF;
			acc_value_q <= '0;
			acc_ref_q   <= '0;
			acc_micro_q <= '0;
			acc_div_q   <= '0;
			acc_size_q  <= '0;
			acc_ovf_q   <= 1'b0;
			out_vld_q   <= 1'b0;
		end else begin
			if (out_load) begin
				out_vld_q <= 1'b1;
			end else if (m_tready) begin
				out_vld_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (pop_valid) begin
						phase_q <= kda_pkg::PH_LEAF;
						state_q <= pop_item.leaf ? ST_LOG : ST_ACC;
					end
				end
				ST_LOG:  state_q <= ST_MLO;
				ST_MLO:  state_q <= ST_MHI;
				ST_MHI:  state_q <= ST_FIN;
				ST_FIN: begin
					acc_ovf_q <= acc_ovf_q | fin_ovf;
					unique case (phase_q)
						kda_pkg::PH_LEAF:  state_q <= ST_ACC;
						kda_pkg::PH_GROUP: state_q <= ST_MERGE;
						default:           state_q <= ST_SCORE;
					endcase
				end
				ST_ACC: begin
					acc_value_q <= sum_v[XW] ? {XW{1'b1}} : sum_v[XW-1:0];
					acc_ref_q   <= sum_r[XW] ? {XW{1'b1}} : sum_r[XW-1:0];
					acc_size_q  <= sum_sz[kda_pkg::GSIZE_W] ? {kda_pkg::GSIZE_W{1'b1}}
						: sum_sz[kda_pkg::GSIZE_W-1:0];
					acc_micro_q <= add_micro[FW-1:0];
					acc_div_q   <= add_div[FW-1:0];
					acc_ovf_q   <= acc_ovf_q | sum_v[XW] | sum_r[XW]
						| sum_sz[kda_pkg::GSIZE_W] | add_micro[FW] | add_div[FW];
					if (item_q.last) begin
						phase_q <= kda_pkg::PH_GROUP;
						state_q <= ST_LOG;
					end else begin
						state_q <= ST_IDLE;
					end
				end
				ST_MERGE: begin
					if (acc_value_q != '0) begin
						acc_ovf_q <= acc_ovf_q | neg_micro_ovf | merge_sum[FW];
					end
					if (score_negative_mode) begin
						state_q <= ST_SCORE;
					end else begin
						phase_q <= kda_pkg::PH_GAIN;
						state_q <= ST_MLO;
					end
				end
				ST_SCORE: begin
					if (out_load) begin
						acc_value_q <= '0;
						acc_ref_q   <= '0;
						acc_micro_q <= '0;
						acc_div_q   <= '0;
						acc_size_q  <= '0;
						acc_ovf_q   <= 1'b0;
						state_q     <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		unique case (state_q)
			ST_IDLE: begin
				if (pop_valid) begin
					item_q <= pop_item;
					term_q <= pop_item.micro;
				end
			end
			ST_LOG: begin
				opa_q <= FW'(log_x);
				opb_q <= 32'(md);
				neg_q <= !d[LW] && (d != '0);
				if (log_x == '0) begin
					spec_q <= kda_pkg::SP_ZERO;
				end else if (log_r == '0) begin
					spec_q <= kda_pkg::SP_MIN;
				end else if (d == '0) begin
					spec_q <= kda_pkg::SP_ZERO;
				end else begin
					spec_q <= kda_pkg::SP_NONE;
				end
			end
			ST_MLO: prod_lo_q <= FW'(opa_q[31:0]) * FW'(opb_q);
			ST_MHI: prod_hi_q <= FW'(opa_q[63:32]) * FW'(opb_q);
			ST_FIN: term_q <= fin_val;
			ST_MERGE: begin
				merged_q <= (acc_value_q == '0) ? '0 : merge_sum[FW-1:0];
				// gain multiply works on the magnitude of the merged divergence
				opa_q  <= (acc_value_q == '0) ? '0
					: (merge_sum[FW-1] ? FW'(0) - merge_sum[FW-1:0] : merge_sum[FW-1:0]);
				opb_q  <= score_gain;
				neg_q  <= (acc_value_q != '0) && merge_sum[FW-1];
				spec_q <= kda_pkg::SP_NONE;
			end
			ST_SCORE: begin
				if (out_load) begin
					out_data_q <= {score_r[FW-1:0], acc_div_q, merged_q, acc_size_q,
						acc_micro_q, acc_ref_q, acc_value_q};
					out_ovf_q  <= acc_ovf_q | score_r[FW];
				end
			end
			default: ;
		endcase
	end

	assign m_tvalid = out_vld_q;
	assign m_tdata  = out_data_q;
	assign m_tuser  = out_ovf_q;

`ifndef SYNTHESIS
	a_load_room: assert property (@(posedge clk) disable iff (!arst_n)
		out_load |-> (!out_vld_q || m_tready))
		else $error("result word loaded over an untaken word");
	a_clear_after_load: assert property (@(posedge clk) disable iff (!arst_n)
		out_load |=> (acc_value_q == '0 && acc_size_q == '0 && !acc_ovf_q))
		else $error("accumulators not cleared after group end");
	a_merge_phase: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_MERGE) |-> (phase_q == kda_pkg::PH_GROUP))
		else $error("merge step outside group end");
	a_gain_no_spec: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_FIN && phase_q == kda_pkg::PH_GAIN) |-> (spec_q == kda_pkg::SP_NONE))
		else $error("gain product flagged as special case");
`endif

endmodule
`default_nettype wire

// ===== design/kl_divergence_aggregator.sv =====
// Top level of the divergence aggregator: configuration registers, front end,
// item queue and compute back end. Depends on kda_pkg, kda_front, kda_fifo, kda_back.
//
// Usage:
//   s_* carries input words: tdata holds the count, reference and part fields,
//   tuser is the mode (0 leaf, 1 part), tlast closes a group.
//   m_* carries one result word per group: tdata holds the sums, merged and
//   part divergences and the score, tuser is the overflow flag.
//   cfg_* writes score_gain (index 0) and score_negative_mode (index 1); cfg_ready
//   is always high; the user writes only while the block is idle (not enforced).
// Sequencing: the back end runs one 32x32 multiplier as a sequencer. A leaf
//   word passes through log, low and high multiply halves, finish and accumulate;
//   a part word is accumulated directly. The last word of a group adds the merged
//   log term, the merge step and the output load, plus the gain product unless
//   negative mode is set. The front register and queue keep taking words while
//   the back end works; the back end takes the next word only when idle.
// Reset: arst_n clears the accumulators and queue; gain resets to 1.0.
// Stall: a held result waits in the output register; the back end keeps
//   accumulating the next group and holds only at that group's end.
`default_nettype none
module kl_divergence_aggregator #(
	parameter int FRAC_BITS      = kda_pkg::FRAC_BITS_DEF,
	parameter int LOG_TABLE_BITS = kda_pkg::LOG_TABLE_BITS_DEF,
	parameter int QUEUE_DEPTH    = kda_pkg::QUEUE_DEPTH_DEF
) (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	input  wire logic                            s_tvalid,
	output logic                                 s_tready,
	// item_value, item_ref, part_micro, part_size, part_divergence, zero pad
	input  wire logic [kda_pkg::IN_DATA_W-1:0]   s_tdata,
	// mode
	input  wire logic                            s_tuser,
	input  wire logic                            s_tlast,
	output logic                                 m_tvalid,
	input  wire logic                            m_tready,
	// sum_value, sum_ref, micro_sum, group_size, merged_divergence,
	// parts_divergence, score
	output logic      [kda_pkg::OUT_DATA_W-1:0]  m_tdata,
	// overflow
	output logic                                 m_tuser,
	input  wire logic                            cfg_valid,
	output logic                                 cfg_ready,
	input  wire logic [kda_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  wire logic [kda_pkg::GAIN_W-1:0]      cfg_data
);

	logic [kda_pkg::GAIN_W-1:0] gain_q;
	logic                       neg_mode_q;
	logic                       push_valid;
	logic                       push_ready;
	kda_pkg::item_t             push_item;
	logic                       pop_valid;
	logic                       pop_ready;
	kda_pkg::item_t             pop_item;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gain_q     <= kda_pkg::GAIN_RESET;
			neg_mode_q <= 1'b0;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				kda_pkg::REG_SCORE_GAIN:    gain_q     <= cfg_data;
				kda_pkg::REG_NEGATIVE_MODE: neg_mode_q <= cfg_data[0];
				default: ;
			endcase
		end
	end

	kda_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.s_tvalid   (s_tvalid),
		.s_tready   (s_tready),
		.s_tdata    (s_tdata),
		.s_tuser    (s_tuser),
		.s_tlast    (s_tlast),
		.push_valid (push_valid),
		.push_ready (push_ready),
		.push_item  (push_item)
	);

	kda_fifo #(.DEPTH(QUEUE_DEPTH)) u_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (push_valid),
		.in_ready  (push_ready),
		.in_item   (push_item),
		.out_valid (pop_valid),
		.out_ready (pop_ready),
		.out_item  (pop_item)
	);

	kda_back #(.FRAC_BITS(FRAC_BITS), .LOG_TABLE_BITS(LOG_TABLE_BITS)) u_back (
		.clk                 (clk),
		.arst_n              (arst_n),
		.pop_valid           (pop_valid),
		.pop_ready           (pop_ready),
		.pop_item            (pop_item),
		.score_gain          (gain_q),
		.score_negative_mode (neg_mode_q),
		.m_tvalid            (m_tvalid),
		.m_tready            (m_tready),
		.m_tdata             (m_tdata),
		.m_tuser             (m_tuser)
	);

endmodule
`default_nettype wire
